@@ sv/cartridge_bank_controller_macros.svh @@
// Assertion macros shared by the cartridge bank controller RTL.
// Every user must have a clock named clk and an active-low reset named arst_n in scope.
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/cbc_pkg.sv @@
`timescale 1ns / 1ps
// Types and constants for the cartridge bank controller.
// No dependencies; every other file but the macros header imports this package.
package cbc_pkg;

	localparam int CFG_W          = 24;
	localparam int BUS_ADDR_W     = 16;
	localparam int DATA_W         = 8;
	localparam int ROM_ADDR_W     = 23;
	localparam int ROM_BANK_W     = 9;
	localparam int ROM_OFF_W      = 14;
	localparam int RAM_ADDR_MAX_W = 17;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ROM  = 2'd1,
		KIND_RAM  = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		CFG_CART_TYPE = 2'd0,
		CFG_ROM_SIZE  = 2'd1,
		CFG_RAM_SIZE  = 2'd2
	} cfg_index_t;

	// Top three address bits split the bus into 8KB windows.
	typedef enum logic [2:0] {
		REGION_RAM_EN   = 3'b000,
		REGION_ROM_BANK = 3'b001,
		REGION_RAM_BANK = 3'b010,
		REGION_MODE     = 3'b011,
		REGION_RAM      = 3'b101
	} bus_region_t;

	localparam logic [7:0]  MBC1_FIRST      = 8'h01;
	localparam logic [7:0]  MBC1_LAST       = 8'h03;
	localparam logic [7:0]  MBC3_FIRST      = 8'h0F;
	localparam logic [7:0]  MBC3_LAST       = 8'h13;
	localparam logic [7:0]  MBC5_FIRST      = 8'h19;
	localparam logic [7:0]  MBC5_LAST       = 8'h1E;
	localparam logic [7:0]  RAM_ENABLE_KEY  = 8'h0A;
	localparam logic [23:0] MBC1_LARGE_ROM  = 24'h040000;
	localparam logic [7:0]  RAM_DISABLED_RD = 8'hFF;
	localparam logic [23:0] ROM_SIZE_RESET  = 24'd32768;

	// Single-port memory request from the controller to the RAM.
	typedef struct packed {
		logic                      rd;
		logic                      wr;
		logic [RAM_ADDR_MAX_W-1:0] addr;
		logic [DATA_W-1:0]         wdata;
	} ram_req_t;

endpackage

@@ sv/cbc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels for bus access words and result words.
// Depends on cbc_pkg for field widths.
interface cbc_req_if import cbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [BUS_ADDR_W-1:0] bus_address;
	logic [DATA_W-1:0]     write_data;

	modport source(output valid, req_type, bus_address, write_data, input ready);
	modport sink(input valid, req_type, bus_address, write_data, output ready);
endinterface

interface cbc_rsp_if import cbc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            result_kind;
	logic [ROM_ADDR_W-1:0] rom_address;
	logic [DATA_W-1:0]     read_data;

	modport source(output valid, result_kind, rom_address, read_data, input ready);
	modport sink(input valid, result_kind, rom_address, read_data, output ready);
endinterface

@@ sv/cartridge_bank_controller.sv @@
`timescale 1ns / 1ps
// Cartridge memory bank controller top level: bank registers, access pipeline, result register.
// Depends on cbc_pkg, cbc_if, cbc_ram and cartridge_bank_controller_macros.svh.
`include "cartridge_bank_controller_macros.svh"

// Handheld-console cartridge bank controller with the MBC1, MBC3 and MBC5 ROM bank rules
// and RAM_BANK_COUNT x 8KB of cartridge RAM on board. Each word on req is one CPU bus
// access; each produces exactly one word on rsp, in order. A ROM read returns the physical
// ROM byte address, a cartridge RAM read returns the stored byte (0xFF while RAM is
// disabled), and every other access returns kind "none". The block accepts one word per
// cycle when rsp keeps up. The result of a word passes through stage 1, where the RAM is
// read synchronously, and then through the output register. Because the RAM has a single
// port and every access uses it at most once, no access ever waits for another. After
// reset the RAM is swept to zero, one byte per cycle, and req.ready stays low while the
// sweep runs; configuration writes are taken as usual meanwhile. Configuration registers
// must be written only while no access is in flight.
module cartridge_bank_controller import cbc_pkg::*; #(
	parameter int RAM_BANK_COUNT = 4,
	parameter int RAM_BANK_BYTES = 8192
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	cbc_req_if.sink          req,
	cbc_rsp_if.source        rsp
);

	localparam int OFF_W = $clog2(RAM_BANK_BYTES);
	localparam int DEPTH = RAM_BANK_COUNT * RAM_BANK_BYTES;
	localparam int AW    = $clog2(DEPTH);

	// Configuration registers.
	logic [7:0]  cart_code_q;
	logic [23:0] rom_bytes_q;
	logic [15:0] ram_bytes_q;

	// Bank state. The bank-select value only ever reaches the accesses through the
	// active bank, which a bank write updates directly in mode 1, so it is not kept apart.
	logic                  ram_enable_q;
	logic [ROM_BANK_W-1:0] rom_bank_q;
	logic [1:0]            ram_bank_act_q;
	logic                  bank_mode_q;

	// Pipeline stage 1 (RAM read in flight) and the output register.
	logic                  v_s1;
	result_kind_t          kind_s1;
	logic [ROM_ADDR_W-1:0] rom_addr_s1;
	logic                  ram_en_s1;
	logic                  out_v_q;
	result_kind_t          kind_q;
	logic [ROM_ADDR_W-1:0] rom_addr_q;
	logic [DATA_W-1:0]     read_data_q;

	logic              acc;
	logic              is_wr;
	logic              is_mbc1;
	logic              is_mbc3;
	logic              is_mbc5;
	bus_region_t       region;
	logic              ram_win;
	logic              ctrl_wr;
	logic [1:0]        ram_bank_raw;
	logic [1:0]        ram_bank;
	logic [4:0]        mbc1_bank;
	logic [6:0]        mbc3_bank;
	result_kind_t      kind_d;
	logic [ROM_ADDR_W-1:0] rom_addr_d;
	logic              s1_move;
	logic              clearing;
	logic [DATA_W-1:0] ram_rdata;
	ram_req_t          ram_req;

	// Bank number modulo RAM_BANK_COUNT by repeated subtraction; the bank is only two bits.
	function automatic logic [1:0] bank_wrap(input logic [1:0] b);
		logic [1:0] r;
		r = b;
		for (int i = 0; i < 3; i++) begin
			if (int'(r) >= RAM_BANK_COUNT) begin
				r = r - 2'(RAM_BANK_COUNT);
			end
		end
		return r;
	endfunction

	assign acc     = req.valid && req.ready;
	assign is_wr   = req.req_type;
	assign region  = bus_region_t'(req.bus_address[15:13]);
	assign ram_win = (region == REGION_RAM);
	assign ctrl_wr = acc && is_wr && !req.bus_address[15];

	assign is_mbc1 = (cart_code_q >= MBC1_FIRST) && (cart_code_q <= MBC1_LAST);
	assign is_mbc3 = (cart_code_q >= MBC3_FIRST) && (cart_code_q <= MBC3_LAST);
	assign is_mbc5 = (cart_code_q >= MBC5_FIRST) && (cart_code_q <= MBC5_LAST);

	// MBC1 in mode 0 always uses RAM bank 0.
	assign ram_bank_raw = (is_mbc1 && !bank_mode_q) ? 2'd0 : ram_bank_act_q;
	assign ram_bank     = bank_wrap(ram_bank_raw);

	// MBC1 and MBC3 turn a zero bank into one; MBC1 does so before its size mask is applied.
	always_comb begin
		mbc1_bank = (req.write_data[4:0] == 5'd0) ? 5'd1 : req.write_data[4:0];
		if (rom_bytes_q <= MBC1_LARGE_ROM) begin
			mbc1_bank[4] = 1'b0;
		end
		mbc3_bank = (req.write_data[6:0] == 7'd0) ? 7'd1 : req.write_data[6:0];
	end

	// Result kind and ROM address of the access being accepted.
	always_comb begin
		kind_d     = KIND_NONE;
		rom_addr_d = '0;
		if (!is_wr && !req.bus_address[15]) begin
			kind_d = KIND_ROM;
			if (req.bus_address[14]) begin
				rom_addr_d = {rom_bank_q, req.bus_address[ROM_OFF_W-1:0]};
			end else begin
				rom_addr_d = ROM_ADDR_W'(req.bus_address[ROM_OFF_W-1:0]);
			end
		end else if (!is_wr && ram_win) begin
			kind_d = KIND_RAM;
		end
	end

	// Memory request: a RAM write needs RAM enabled and a nonzero RAM size; a read is
	// skipped while RAM is disabled since its data is replaced by 0xFF anyway.
	always_comb begin
		ram_req.wr    = acc && is_wr && ram_win && ram_enable_q && (ram_bytes_q != '0);
		ram_req.rd    = acc && !is_wr && ram_win && ram_enable_q;
		ram_req.addr  = RAM_ADDR_MAX_W'({4'(ram_bank), req.bus_address[OFF_W-1:0]});
		ram_req.wdata = req.write_data;
	end

	// Stage 1 advances when the output register is empty or being emptied. The RAM data
	// register only loads on a read, so it holds while stage 1 waits.
	assign s1_move   = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !clearing && (!v_s1 || s1_move);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_code_q <= '0;
			rom_bytes_q <= ROM_SIZE_RESET;
			ram_bytes_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_CART_TYPE: cart_code_q <= cfg_wdata[7:0];
				CFG_ROM_SIZE:  rom_bytes_q <= cfg_wdata[23:0];
				CFG_RAM_SIZE:  ram_bytes_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Control register writes land at the accept edge, so the next access already sees them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_enable_q   <= 1'b0;
			rom_bank_q     <= ROM_BANK_W'(1);
			ram_bank_act_q <= '0;
			bank_mode_q    <= 1'b0;
		end else if (ctrl_wr) begin
			case (region)
				REGION_RAM_EN: begin
					ram_enable_q <= (req.write_data == RAM_ENABLE_KEY);
				end
				REGION_ROM_BANK: begin
					if (is_mbc1) begin
						rom_bank_q <= ROM_BANK_W'(mbc1_bank);
					end else if (is_mbc3) begin
						rom_bank_q <= ROM_BANK_W'(mbc3_bank);
					end else if (is_mbc5) begin
						// The low byte sits below 0x3000, the ninth bit above it.
						if (!req.bus_address[12]) begin
							rom_bank_q[7:0] <= req.write_data;
						end else begin
							rom_bank_q[8] <= req.write_data[0];
						end
					end
				end
				REGION_RAM_BANK: begin
					if (bank_mode_q) begin
						ram_bank_act_q <= req.write_data[1:0];
					end
				end
				REGION_MODE: begin
					bank_mode_q <= req.write_data[0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1     <= kind_d;
			rom_addr_s1 <= rom_addr_d;
			ram_en_s1   <= ram_enable_q;
		end
		if (s1_move) begin
			kind_q      <= kind_s1;
			rom_addr_q  <= rom_addr_s1;
			read_data_q <= '0;
			if (kind_s1 == KIND_RAM) begin
				read_data_q <= ram_en_s1 ? ram_rdata : RAM_DISABLED_RD;
			end
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.result_kind = kind_q;
	assign rsp.rom_address = rom_addr_q;
	assign rsp.read_data   = read_data_q;

	cbc_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.clearing(clearing),
		.rdata   (ram_rdata)
	);

	`CBC_ASSERT_NEXT(a_ram_read_reaches_s1, ram_req.rd, v_s1 && (kind_s1 == KIND_RAM), "RAM read lost")
	`CBC_ASSERT_NEXT(a_s1_holds_on_stall, v_s1 && !s1_move, v_s1 && $stable(rom_addr_s1), "stage 1 dropped")
	`CBC_ASSERT_NOW(a_rom_addr_only_for_rom, out_v_q && (kind_q != KIND_ROM), rom_addr_q == '0, "stray ROM address")

endmodule

@@ sv/cbc_ram.sv @@
`timescale 1ns / 1ps
// Single-port cartridge RAM with a clearing sweep after reset.
// Depends on cbc_pkg and cartridge_bank_controller_macros.svh.
`include "cartridge_bank_controller_macros.svh"

module cbc_ram import cbc_pkg::*; #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ram_req_t          req,
	output logic              clearing,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [AW-1:0]     clr_ctr_q;
	logic              clearing_q;
	logic [DATA_W-1:0] rdata_q;
	logic [AW-1:0]     addr;

	assign addr     = AW'(req.addr);
	assign clearing = clearing_q;
	assign rdata    = rdata_q;

	// The sweep writes one zero per cycle, then stays off until the next reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_ctr_q  <= '0;
		end else if (clearing_q) begin
			clr_ctr_q <= clr_ctr_q + 1'b1;
			if (clr_ctr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_ctr_q] <= '0;
		end else if (req.wr) begin
			mem[addr] <= req.wdata;
		end
		if (!clearing_q && req.rd) begin
			rdata_q <= mem[addr];
		end
	end

	`CBC_ASSERT_NOW(a_no_access_while_clearing, clearing_q, !(req.rd || req.wr), "RAM access during clear")
	`CBC_ASSERT_NOW(a_single_port, req.rd, !req.wr, "RAM read and write in one cycle")
	`CBC_ASSERT_NEXT(a_clear_runs_once, !clearing_q, !clearing_q, "clear sweep restarted without reset")

endmodule
